// ===== rtl/core/gee_pkg.sv =====
// ----------------------------------------------------------------------------
// gee_pkg - shared types and constants of the gamepad edge event generator
// Logical button positions, event codes, register indexes and the structs
// passed between the decoder and the top level.
// ----------------------------------------------------------------------------
package gee_pkg;

  // Logical buttons, in event order; also the bit positions of the held state
  localparam int NUM_BTN = 12;
  localparam logic [3:0] POS_UP     = 4'd0;
  localparam logic [3:0] POS_DOWN   = 4'd1;
  localparam logic [3:0] POS_LEFT   = 4'd2;
  localparam logic [3:0] POS_RIGHT  = 4'd3;
  localparam logic [3:0] POS_A      = 4'd4;
  localparam logic [3:0] POS_B      = 4'd5;
  localparam logic [3:0] POS_X      = 4'd6;
  localparam logic [3:0] POS_Y      = 4'd7;
  localparam logic [3:0] POS_L      = 4'd8;
  localparam logic [3:0] POS_R      = 4'd9;
  localparam logic [3:0] POS_START  = 4'd10;
  localparam logic [3:0] POS_SELECT = 4'd11;

  // Event codes
  localparam logic [3:0] EV_UP       = 4'd0;
  localparam logic [3:0] EV_DOWN     = 4'd1;
  localparam logic [3:0] EV_LEFT     = 4'd2;
  localparam logic [3:0] EV_RIGHT    = 4'd3;
  localparam logic [3:0] EV_ROTLEFT  = 4'd4;
  localparam logic [3:0] EV_ROTRIGHT = 4'd5;
  localparam logic [3:0] EV_A        = 4'd6;
  localparam logic [3:0] EV_B        = 4'd7;
  localparam logic [3:0] EV_X        = 4'd8;
  localparam logic [3:0] EV_Y        = 4'd9;
  localparam logic [3:0] EV_L        = 4'd10;
  localparam logic [3:0] EV_R        = 4'd11;
  localparam logic [3:0] EV_START    = 4'd12;
  localparam logic [3:0] EV_SELECT   = 4'd13;

  // Configuration register indexes
  localparam logic [1:0] REG_JOYSTICK_PRESENT = 2'd0;
  localparam logic [1:0] REG_AXIS_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_AUX_AXES_IN_USE  = 2'd2;

  localparam logic [14:0] THRESHOLD_RESET = 15'd8000;
  localparam logic [2:0]  AUX_IN_USE_RESET = 3'd4;

  // Auxiliary trigger axes: supported count and axis fields on the port
  localparam int AUX_AXES       = 4;
  localparam int NUM_AUX_FIELDS = 4;
  localparam logic [3:0] AUX_LIMIT =
    4'((AUX_AXES < NUM_AUX_FIELDS) ? AUX_AXES : NUM_AUX_FIELDS);

  // Signed axis levels
  localparam logic signed [1:0] AXIS_NEG  = -2'sd1;
  localparam logic signed [1:0] AXIS_NONE = 2'sd0;
  localparam logic signed [1:0] AXIS_POS  = 2'sd1;

  typedef struct packed {
    logic        joystick_present;
    logic [14:0] axis_threshold;
    logic [2:0]  aux_axes_in_use;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BTN-1:0] previous_pressed;
    logic               rotate_latched;
    logic               tilt_latched;
  } mode_state_t;

  typedef struct packed {
    logic [NUM_BTN-1:0] press_mask;
    logic               rotate;
    logic signed [1:0]  yaw;
    logic signed [1:0]  pitch;
    mode_state_t        state_next;
  } decode_t;

  // Event code for a button position; left and right turn into rotate events
  function automatic logic [3:0] event_code_of(input logic [3:0] pos, input logic rotate);
    logic [3:0] code;
    unique case (pos)
      POS_UP:     code = EV_UP;
      POS_DOWN:   code = EV_DOWN;
      POS_LEFT:   code = rotate ? EV_ROTLEFT : EV_LEFT;
      POS_RIGHT:  code = rotate ? EV_ROTRIGHT : EV_RIGHT;
      POS_A:      code = EV_A;
      POS_B:      code = EV_B;
      POS_X:      code = EV_X;
      POS_Y:      code = EV_Y;
      POS_L:      code = EV_L;
      POS_R:      code = EV_R;
      POS_START:  code = EV_START;
      POS_SELECT: code = EV_SELECT;
      default:    code = EV_UP;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/gee_decode.sv =====
// ----------------------------------------------------------------------------
// gee_decode - poll decoder
// Combines one poll into twelve logical buttons, resolves rotate and tilt
// modes and gives the press mask and the next held state.
// ----------------------------------------------------------------------------
module gee_decode (
  input  gee_pkg::cfg_t        cfg,
  input  gee_pkg::mode_state_t state,
  input  logic [3:0]           hat_bits,
  input  logic [7:0]           button_bits,
  input  logic [11:0]          key_bits,
  input  logic signed [15:0]   axis_x,
  input  logic signed [15:0]   axis_y,
  input  logic signed [15:0]   aux_axis_a,
  input  logic signed [15:0]   aux_axis_b,
  input  logic signed [15:0]   aux_axis_c,
  input  logic signed [15:0]   aux_axis_d,
  output gee_pkg::decode_t     dec
);

  logic signed [16:0] thr_pos;
  logic signed [16:0] thr_neg;
  logic signed [15:0] aux [gee_pkg::NUM_AUX_FIELDS];
  logic [3:0]  aux_n;
  logic        trig_axis;
  logic [gee_pkg::NUM_BTN-1:0] joy;
  logic [gee_pkg::NUM_BTN-1:0] cur;
  logic [gee_pkg::NUM_BTN-1:0] skip;
  logic        shoulder;
  logic        trigger;
  logic        rotate;
  logic        tilt;

  assign thr_pos = $signed({2'b00, cfg.axis_threshold});
  assign thr_neg = -thr_pos;

  assign aux[0] = aux_axis_a;
  assign aux[1] = aux_axis_b;
  assign aux[2] = aux_axis_c;
  assign aux[3] = aux_axis_d;

  assign aux_n = ({1'b0, cfg.aux_axes_in_use} > gee_pkg::AUX_LIMIT) ?
                 gee_pkg::AUX_LIMIT : {1'b0, cfg.aux_axes_in_use};

  always_comb begin
    trig_axis = 1'b0;
    for (int i = 0; i < gee_pkg::NUM_AUX_FIELDS; i++) begin
      if ((4'(i) < aux_n) && (17'(aux[i]) > thr_pos)) trig_axis = 1'b1;
    end
  end

  // Joystick contribution: hat and buttons, axes as fallback directions
  always_comb begin
    joy = '0;
    if (cfg.joystick_present) begin
      joy[gee_pkg::POS_UP]     = hat_bits[0] | (17'(axis_y) < thr_neg);
      joy[gee_pkg::POS_RIGHT]  = hat_bits[1] | (17'(axis_x) > thr_pos);
      joy[gee_pkg::POS_DOWN]   = hat_bits[2] | (17'(axis_y) > thr_pos);
      joy[gee_pkg::POS_LEFT]   = hat_bits[3] | (17'(axis_x) < thr_neg);
      joy[gee_pkg::POS_B]      = button_bits[0];
      joy[gee_pkg::POS_A]      = button_bits[1];
      joy[gee_pkg::POS_Y]      = button_bits[2];
      joy[gee_pkg::POS_X]      = button_bits[3];
      joy[gee_pkg::POS_L]      = button_bits[4];
      joy[gee_pkg::POS_R]      = button_bits[5];
      joy[gee_pkg::POS_SELECT] = button_bits[6];
      joy[gee_pkg::POS_START]  = button_bits[7];
    end
  end

  // Keys follow the event order except that select comes before start
  always_comb begin
    cur = joy;
    cur[9:0] = joy[9:0] | key_bits[9:0];
    cur[gee_pkg::POS_SELECT] = joy[gee_pkg::POS_SELECT] | key_bits[10];
    cur[gee_pkg::POS_START]  = joy[gee_pkg::POS_START] | key_bits[11];
  end

  assign shoulder = (cur[gee_pkg::POS_L] | cur[gee_pkg::POS_R]) &
                    (|cur[3:0]);
  assign trigger  = (cfg.joystick_present & trig_axis) | shoulder;
  assign rotate   = (cur[gee_pkg::POS_LEFT] | cur[gee_pkg::POS_RIGHT]) &
                    (trigger | state.rotate_latched);
  assign tilt     = (cur[gee_pkg::POS_UP] | cur[gee_pkg::POS_DOWN]) &
                    (trigger | state.tilt_latched);

  always_comb begin
    skip = '0;
    skip[gee_pkg::POS_UP]   = tilt;
    skip[gee_pkg::POS_DOWN] = tilt;
    skip[gee_pkg::POS_L]    = shoulder;
    skip[gee_pkg::POS_R]    = shoulder;
  end

  always_comb begin
    dec.press_mask = cur & ~state.previous_pressed & ~skip;
    dec.rotate     = rotate;
    if (!rotate) dec.yaw = gee_pkg::AXIS_NONE;
    else if (cur[gee_pkg::POS_LEFT]) dec.yaw = gee_pkg::AXIS_NEG;
    else dec.yaw = gee_pkg::AXIS_POS;
    if (!tilt) dec.pitch = gee_pkg::AXIS_NONE;
    else if (cur[gee_pkg::POS_DOWN]) dec.pitch = gee_pkg::AXIS_POS;
    else dec.pitch = gee_pkg::AXIS_NEG;
    dec.state_next.previous_pressed = (cur & ~skip) | (state.previous_pressed & skip);
    dec.state_next.rotate_latched   = rotate;
    dec.state_next.tilt_latched     = tilt;
  end

endmodule

// ===== rtl/core/gamepad_edge_event_generator_unit.sv =====
// ----------------------------------------------------------------------------
// gamepad_edge_event_generator_unit - gamepad button edge event generator
// Turns polls of hat, buttons, keys and axes into serialised press events
// with the continuous rotate and pitch axes of each poll.
// ----------------------------------------------------------------------------
// Each accepted poll is decoded in the cycle it is taken: the twelve logical
// buttons, the rotate and tilt modes and the held state are settled at once,
// and the poll's press events wait as a bit mask in a pending register. One
// item leaves per cycle from the output register while out_ready is high,
// lowest button position first; a poll that presses nothing still sends a
// single item with event_valid low that carries the axes. last_of_run marks
// the final item of each poll. The next poll is taken in the same cycle as
// the previous poll's last item moves to the output register, so polls with
// at most one event stream at one per cycle while out_ready is high.
// Configuration registers are to be written through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce
// this. An index beyond the last register is dropped.
// ----------------------------------------------------------------------------
module gamepad_edge_event_generator_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  // poll items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         hat_bits,
  input  logic [7:0]         button_bits,
  input  logic [11:0]        key_bits,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] aux_axis_a,
  input  logic signed [15:0] aux_axis_b,
  input  logic signed [15:0] aux_axis_c,
  input  logic signed [15:0] aux_axis_d,
  // event items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               event_valid,
  output logic [3:0]         event_code,
  output logic               last_of_run,
  output logic signed [1:0]  rotate_axis,
  output logic signed [1:0]  pitch_axis
);

  gee_pkg::cfg_t        cfg;
  gee_pkg::mode_state_t state;
  gee_pkg::decode_t     dec;

  // pending poll: events still to be sent
  logic                        pend_busy;
  logic [gee_pkg::NUM_BTN-1:0] pend_mask;
  logic                        pend_rotate;
  logic signed [1:0]           pend_yaw;
  logic signed [1:0]           pend_pitch;

  logic                        in_accept;
  logic                        advance;
  logic                        sel_found;
  logic [3:0]                  sel_pos;
  logic [gee_pkg::NUM_BTN-1:0] mask_rest;
  logic                        sel_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.joystick_present <= 1'b0;
      cfg.axis_threshold   <= gee_pkg::THRESHOLD_RESET;
      cfg.aux_axes_in_use  <= gee_pkg::AUX_IN_USE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gee_pkg::REG_JOYSTICK_PRESENT: cfg.joystick_present <= cfg_data[0];
        gee_pkg::REG_AXIS_THRESHOLD:   cfg.axis_threshold   <= cfg_data;
        gee_pkg::REG_AUX_AXES_IN_USE:  cfg.aux_axes_in_use  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  gee_decode u_decode (
    .cfg         (cfg),
    .state       (state),
    .hat_bits    (hat_bits),
    .button_bits (button_bits),
    .key_bits    (key_bits),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .aux_axis_a  (aux_axis_a),
    .aux_axis_b  (aux_axis_b),
    .aux_axis_c  (aux_axis_c),
    .aux_axis_d  (aux_axis_d),
    .dec         (dec)
  );

  // Pick the lowest pending position; the scan runs high to low so the
  // lowest set bit is written last
  always_comb begin
    sel_found = 1'b0;
    sel_pos   = gee_pkg::POS_UP;
    for (int k = gee_pkg::NUM_BTN - 1; k >= 0; k--) begin
      if (pend_mask[k]) begin
        sel_found = 1'b1;
        sel_pos   = 4'(k);
      end
    end
  end

  always_comb begin
    mask_rest = pend_mask;
    if (sel_found) mask_rest[sel_pos] = 1'b0;
  end

  assign sel_last  = (mask_rest == '0);
  assign advance   = pend_busy && (!out_valid || out_ready);
  // take a new poll when nothing is pending, or as the last item leaves
  assign in_ready  = !pend_busy || (advance && sel_last);
  assign in_accept = in_valid && in_ready;

  // Held button state and latched modes advance as each poll is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= dec.state_next;
    end
  end

  // Pending register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_busy <= 1'b0;
    end else if (in_accept) begin
      pend_busy <= 1'b1;
    end else if (advance && sel_last) begin
      pend_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_mask   <= dec.press_mask;
      pend_rotate <= dec.rotate;
      pend_yaw    <= dec.yaw;
      pend_pitch  <= dec.pitch;
    end else if (advance) begin
      pend_mask   <= mask_rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_valid <= sel_found;
      event_code  <= sel_found ? gee_pkg::event_code_of(sel_pos, pend_rotate)
                               : gee_pkg::EV_UP;
      last_of_run <= sel_last;
      rotate_axis <= pend_yaw;
      pitch_axis  <= pend_pitch;
    end
  end

`ifndef SYNTHESIS
  // an item without an event is always the only and last item of its poll
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> last_of_run)
    else $error("empty item not marked last");

  // rotate events only come with a nonzero yaw
  a_rotate_has_yaw: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid &&
    (event_code == gee_pkg::EV_ROTLEFT || event_code == gee_pkg::EV_ROTRIGHT)
    |-> rotate_axis != gee_pkg::AXIS_NONE)
    else $error("rotate event without yaw");

  // a poll is taken only when the pending register is free or draining
  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !pend_busy || (advance && sel_last))
    else $error("poll taken over pending events");

  // an accepted poll always leaves something pending
  a_accept_pends: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> pend_busy)
    else $error("accepted poll not pending");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb - testbench of the gamepad edge event generator
// Streams polls through the valid/ready input with random gaps, stalls the
// event output at random, and checks every event item against a predictor
// that keeps its own copy of the registers, the held buttons and the
// rotate and tilt latches. Covers directed corner polls first, then random
// press/release sequences under several register settings.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound: ~460 polls, twelve events each, the longest output stall
  // on every event, plus sender gaps, taken several times over
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to let pass once the last event item has come back
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic [3:0]         hat;
    logic [7:0]         btn;
    logic [11:0]        keys;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] aux_a;
    logic signed [15:0] aux_b;
    logic signed [15:0] aux_c;
    logic signed [15:0] aux_d;
  } poll_t;

  typedef struct {
    logic              ev_valid;
    logic [3:0]        code;
    logic              last;
    logic signed [1:0] yaw;
    logic signed [1:0] pitch;
  } press_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = gee_pkg::REG_JOYSTICK_PRESENT;
  logic [14:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         hat_bits = '0;
  logic [7:0]         button_bits = '0;
  logic [11:0]        key_bits = '0;
  logic signed [15:0] axis_x = '0;
  logic signed [15:0] axis_y = '0;
  logic signed [15:0] aux_axis_a = '0;
  logic signed [15:0] aux_axis_b = '0;
  logic signed [15:0] aux_axis_c = '0;
  logic signed [15:0] aux_axis_d = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              event_valid;
  logic [3:0]        event_code;
  logic              last_of_run;
  logic signed [1:0] rotate_axis;
  logic signed [1:0] pitch_axis;

  gamepad_edge_event_generator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .hat_bits    (hat_bits),
    .button_bits (button_bits),
    .key_bits    (key_bits),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .aux_axis_a  (aux_axis_a),
    .aux_axis_b  (aux_axis_b),
    .aux_axis_c  (aux_axis_c),
    .aux_axis_d  (aux_axis_d),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_valid (event_valid),
    .event_code  (event_code),
    .last_of_run (last_of_run),
    .rotate_axis (rotate_axis),
    .pitch_axis  (pitch_axis)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow registers, at their reset values
  logic        joy_present = 1'b0;
  logic [14:0] threshold = gee_pkg::THRESHOLD_RESET;
  logic [2:0]  aux_count = gee_pkg::AUX_IN_USE_RESET;

  // Predictor's copy of the held buttons and the mode latches
  logic [gee_pkg::NUM_BTN-1:0] held_prev = '0;
  logic                        rotate_latch = 1'b0;
  logic                        tilt_latch = 1'b0;

  poll_t        pending_polls[$];
  press_event_t awaited_events[$];
  poll_t        driven_poll;
  press_event_t got_want;

  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  // Set for the closing stretch of the run: no gaps, no stalls
  logic calm = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor: fold one poll into the twelve logical buttons, settle the
  // modes and append the poll's press events, last one marked
  // --------------------------------------------------------------------------
  function automatic void predict_poll_events(input poll_t p);
    logic [gee_pkg::NUM_BTN-1:0] now;
    logic               trig;
    logic               shoulder;
    logic               rot;
    logic               tilt;
    logic               skip;
    logic signed [1:0]  yaw;
    logic signed [1:0]  pitch;
    logic signed [15:0] aux_vals [4];
    int                 thr;
    int                 n;
    press_event_t       ev;
    press_event_t       run[$];

    now  = '0;
    trig = 1'b0;
    thr  = int'(threshold);
    aux_vals = '{p.aux_a, p.aux_b, p.aux_c, p.aux_d};

    if (joy_present) begin
      now[gee_pkg::POS_UP]     = p.hat[0];
      now[gee_pkg::POS_RIGHT]  = p.hat[1];
      now[gee_pkg::POS_DOWN]   = p.hat[2];
      now[gee_pkg::POS_LEFT]   = p.hat[3];
      now[gee_pkg::POS_B]      = p.btn[0];
      now[gee_pkg::POS_A]      = p.btn[1];
      now[gee_pkg::POS_Y]      = p.btn[2];
      now[gee_pkg::POS_X]      = p.btn[3];
      now[gee_pkg::POS_L]      = p.btn[4];
      now[gee_pkg::POS_R]      = p.btn[5];
      now[gee_pkg::POS_SELECT] = p.btn[6];
      now[gee_pkg::POS_START]  = p.btn[7];
      // Clamp the axis count to what the block supports
      n = int'(aux_count);
      if (n > int'(gee_pkg::AUX_LIMIT)) n = int'(gee_pkg::AUX_LIMIT);
      for (int i = 0; i < n; i++)
        if (int'(aux_vals[i]) > thr) trig = 1'b1;
      // Axes only add to the hat, never clear it
      if (int'(p.ax) > thr) now[gee_pkg::POS_RIGHT] = 1'b1;
      else if (int'(p.ax) < -thr) now[gee_pkg::POS_LEFT] = 1'b1;
      if (int'(p.ay) > thr) now[gee_pkg::POS_DOWN] = 1'b1;
      else if (int'(p.ay) < -thr) now[gee_pkg::POS_UP] = 1'b1;
    end

    // Keys follow button order except start and select, which swap places
    now = now | {p.keys[10], p.keys[11], p.keys[9:0]};

    shoulder = (now[gee_pkg::POS_L] | now[gee_pkg::POS_R]) &
               (|now[gee_pkg::POS_RIGHT:gee_pkg::POS_UP]);
    trig     = trig | shoulder;
    rot      = (now[gee_pkg::POS_LEFT] | now[gee_pkg::POS_RIGHT]) & (trig | rotate_latch);
    tilt     = (now[gee_pkg::POS_UP] | now[gee_pkg::POS_DOWN]) & (trig | tilt_latch);
    rotate_latch = rot;
    tilt_latch   = tilt;
    yaw   = !rot ? gee_pkg::AXIS_NONE :
            (now[gee_pkg::POS_LEFT] ? gee_pkg::AXIS_NEG : gee_pkg::AXIS_POS);
    pitch = !tilt ? gee_pkg::AXIS_NONE :
            (now[gee_pkg::POS_DOWN] ? gee_pkg::AXIS_POS : gee_pkg::AXIS_NEG);

    for (int k = 0; k < gee_pkg::NUM_BTN; k++) begin
      // Consumed buttons raise nothing and keep their held bit
      skip = (tilt && (k == gee_pkg::POS_UP || k == gee_pkg::POS_DOWN)) ||
             (shoulder && (k == gee_pkg::POS_L || k == gee_pkg::POS_R));
      if (!skip) begin
        if (now[k] && !held_prev[k]) begin
          ev.ev_valid = 1'b1;
          ev.last     = 1'b0;
          ev.yaw      = yaw;
          ev.pitch    = pitch;
          case (k)
            gee_pkg::POS_UP:    ev.code = gee_pkg::EV_UP;
            gee_pkg::POS_DOWN:  ev.code = gee_pkg::EV_DOWN;
            gee_pkg::POS_LEFT:  ev.code = rot ? gee_pkg::EV_ROTLEFT : gee_pkg::EV_LEFT;
            gee_pkg::POS_RIGHT: ev.code = rot ? gee_pkg::EV_ROTRIGHT : gee_pkg::EV_RIGHT;
            gee_pkg::POS_A:     ev.code = gee_pkg::EV_A;
            gee_pkg::POS_B:     ev.code = gee_pkg::EV_B;
            gee_pkg::POS_X:     ev.code = gee_pkg::EV_X;
            gee_pkg::POS_Y:     ev.code = gee_pkg::EV_Y;
            gee_pkg::POS_L:     ev.code = gee_pkg::EV_L;
            gee_pkg::POS_R:     ev.code = gee_pkg::EV_R;
            gee_pkg::POS_START: ev.code = gee_pkg::EV_START;
            default:            ev.code = gee_pkg::EV_SELECT;
          endcase
          run = {run, ev};
        end
        held_prev[k] = now[k];
      end
    end

    // A quiet poll still reports its axes in one item
    if (run.size() == 0) begin
      ev.ev_valid = 1'b0;
      ev.code     = '0;
      ev.last     = 1'b0;
      ev.yaw      = yaw;
      ev.pitch    = pitch;
      run = {run, ev};
    end
    run[run.size()-1].last = 1'b1;
    awaited_events = {awaited_events, run};
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict on acceptance, then either idle for a burst or present
  // the next pending poll; valid is never dropped before its handshake
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_poll_events(driven_poll);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
          // open an idle burst that starts with this cycle
          send_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_polls.size() != 0) begin
          driven_poll = pending_polls.pop_front();
          hat_bits    <= driven_poll.hat;
          button_bits <= driven_poll.btn;
          key_bits    <= driven_poll.keys;
          axis_x      <= driven_poll.ax;
          axis_y      <= driven_poll.ay;
          aux_axis_a  <= driven_poll.aux_a;
          aux_axis_b  <= driven_poll.aux_b;
          aux_axis_c  <= driven_poll.aux_c;
          aux_axis_d  <= driven_poll.aux_d;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted event item against the oldest awaited one,
  // and stall the output in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_events.size() == 0) begin
          $error("event item with no poll awaiting it: code %0d", event_code);
          fail_count++;
        end else begin
          got_want = awaited_events.pop_front();
          check_field("event_valid", got_want.ev_valid, event_valid);
          check_field("event_code", got_want.code, event_code);
          check_field("last_of_run", got_want.last, last_of_run);
          check_field("rotate_axis", got_want.yaw, rotate_axis);
          check_field("pitch_axis", got_want.pitch, pitch_axis);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_poll(input logic [3:0] hat, input logic [7:0] btn,
                            input logic [11:0] keys,
                            input logic signed [15:0] ax, input logic signed [15:0] ay,
                            input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic signed [15:0] c, input logic signed [15:0] d);
    poll_t p;
    p = '{hat, btn, keys, ax, ay, a, b, c, d};
    pending_polls = {pending_polls, p};
  endtask

  // Hold the sender until every poll is taken and every event has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_polls.size() != 0 || in_valid || awaited_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      gee_pkg::REG_JOYSTICK_PRESENT: joy_present = value[0];
      gee_pkg::REG_AXIS_THRESHOLD:   threshold   = value;
      gee_pkg::REG_AUX_AXES_IN_USE:  aux_count   = value[2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Axis values clustered around the threshold, plus the extremes
  function automatic logic signed [15:0] pick_axis(input int thr);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = thr;
      2: v = -thr;
      3: v = (thr >= 32767) ? 32767 : thr + 1;
      4: v = -thr - 1;
      5: v = 32767;
      6: v = -32768;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return 16'(v);
  endfunction

  // Mostly small changes on the last poll, so buttons go down and up again
  // and modes get latched; the rest is noise or a full release
  function automatic poll_t next_poll(input poll_t prev, input int thr);
    poll_t p;
    int    pick;
    pick = $urandom_range(0, 19);
    p = prev;
    if (pick < 12) begin
      if ($urandom_range(0, 1)) p.hat[$urandom_range(0, 3)] ^= 1'b1;
      if ($urandom_range(0, 1)) p.btn[$urandom_range(0, 7)] ^= 1'b1;
      if ($urandom_range(0, 3) == 0) p.keys[$urandom_range(0, 11)] ^= 1'b1;
      if ($urandom_range(0, 2) == 0) p.ax = pick_axis(thr);
      if ($urandom_range(0, 2) == 0) p.ay = pick_axis(thr);
      case ($urandom_range(0, 5))
        0: p.aux_a = pick_axis(thr);
        1: p.aux_b = pick_axis(thr);
        2: p.aux_c = pick_axis(thr);
        3: p.aux_d = pick_axis(thr);
        default: ;
      endcase
    end else if (pick < 17) begin
      p.hat   = 4'($urandom);
      p.btn   = 8'($urandom);
      p.keys  = 12'($urandom);
      p.ax    = 16'($urandom);
      p.ay    = 16'($urandom);
      p.aux_a = 16'($urandom);
      p.aux_b = 16'($urandom);
      p.aux_c = 16'($urandom);
      p.aux_d = 16'($urandom);
    end else begin
      p = '{4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    poll_t       last_poll;
    logic        ph_joy;
    logic [14:0] ph_thr;
    logic [2:0]  ph_aux;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Joystick absent after reset: only keys count, the rest is ignored
    queue_poll(4'hF, 8'hFF, 12'hFFF, 16'sh7FFF, -16'sd32768, 16'sh7FFF, 16'sh7FFF,
               16'sh7FFF, 16'sh7FFF);
    queue_poll(4'hF, 8'hFF, 12'h000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
               16'sh7FFF, 16'sh7FFF);
    queue_poll(4'h0, 8'h00, 12'h400, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    write_reg(gee_pkg::REG_JOYSTICK_PRESENT, 15'd1);
    write_reg(gee_pkg::REG_AXIS_THRESHOLD, 15'd8000);
    write_reg(gee_pkg::REG_AUX_AXES_IN_USE, 15'd4);
    // nothing held
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // everything on the pad: shoulder and both-direction cases at once
    queue_poll(4'hF, 8'hFF, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // axes at the extremes stand in for the hat
    queue_poll(4'h0, 8'h00, 12'h000, 16'sh7FFF, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h0, 8'h00, 12'h000, -16'sd32768, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // trigger with left latches rotate; rotate then holds without it
    queue_poll(4'h8, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h8, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h2, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // every key, then release
    queue_poll(4'h0, 8'h00, 12'hFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // L with up: shoulder eats L, tilt eats up
    queue_poll(4'h1, 8'h10, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // exactly at the threshold counts as not held
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd8000, -16'sd8000, 16'sd8000, 16'sd8000,
               16'sd8000, 16'sd8000);
    // one past the threshold; the last aux axis alone triggers
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd8001, -16'sd8001, 16'sd0, 16'sd0, 16'sd0,
               16'sd8001);
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    // Threshold zero and an aux count past the supported number
    write_reg(gee_pkg::REG_AXIS_THRESHOLD, 15'd0);
    write_reg(gee_pkg::REG_AUX_AXES_IN_USE, 15'd7);
    queue_poll(4'h4, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
    queue_poll(4'h0, 8'h00, 12'h000, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_poll(4'h0, 8'h00, 12'h000, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    // Largest threshold with no aux axes checked
    write_reg(gee_pkg::REG_AXIS_THRESHOLD, 15'd32767);
    write_reg(gee_pkg::REG_AUX_AXES_IN_USE, 15'd0);
    queue_poll(4'h0, 8'h00, 12'h000, 16'sh7FFF, -16'sd32768, 16'sh7FFF, 16'sh7FFF,
               16'sh7FFF, 16'sh7FFF);
    queue_poll(4'h0, 8'h00, 12'h000, -16'sd32768, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    // Random phases under varied settings; the last one runs without idling
    last_poll = '{4'h0, 8'h00, 12'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    for (int ph = 0; ph < 6; ph++) begin
      ph_joy = (ph == 2) ? 1'b0 : 1'b1;
      case (ph)
        0: ph_thr = 15'd8000;
        1: ph_thr = 15'd0;
        3: ph_thr = 15'd32767;
        4: ph_thr = 15'd200;
        default: ph_thr = 15'($urandom_range(1, 32766));
      endcase
      ph_aux = 3'($urandom_range(0, 7));
      if (ph == 0) ph_aux = 3'd4;
      write_reg(gee_pkg::REG_JOYSTICK_PRESENT, {14'd0, ph_joy});
      write_reg(gee_pkg::REG_AXIS_THRESHOLD, ph_thr);
      write_reg(gee_pkg::REG_AUX_AXES_IN_USE, {12'd0, ph_aux});
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 72; i++) begin
        last_poll = next_poll(last_poll, int'(ph_thr));
        pending_polls = {pending_polls, last_poll};
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
